### hdl/pid_pkg.sv
// Shared types and codes of the palette image decoder.
package pid_pkg;

  localparam int CODE_W  = 32;
  localparam int COLOR_W = 24;
  localparam int INDEX_W = 24;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 13;

  localparam logic [1:0] CMD_HEADER  = 2'd0;
  localparam logic [1:0] CMD_PALETTE = 2'd1;
  localparam logic [1:0] CMD_PIXEL   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HDR_BAD = 2'd1;
  localparam logic [1:0] ST_MISS    = 2'd2;

  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_COLOR_COUNT  = 2'd2;
  localparam logic [1:0] CFG_CODE_CHARS   = 2'd3;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [8:0]  color_count;
    logic [2:0]  code_chars;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] color;
    logic               hdr_bad;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               pixel_valid;
    logic [INDEX_W-1:0] pixel_index;
    logic [VALUE_W-1:0] pixel_value;
  } res_t;

endpackage

### hdl/pid_ram.sv
// Generic simple dual-port RAM with registered read.
module pid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/pid_front.sv
// Front end: takes requests, converts palette text and checks headers.
module pid_front
  import pid_pkg::*;
(
  input  logic        start,
  input  logic        q_full,
  input  cfg_t        cfg,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_code,
  input  logic [47:0] in_hex_text,
  input  logic [15:0] in_header_width,
  input  logic [15:0] in_header_height,
  input  logic [15:0] in_header_colors,
  input  logic [15:0] in_header_chars,
  output logic        busy,
  output logic        q_push,
  output item_t       q_item
);

  function automatic logic [3:0] hex_digit(input logic [7:0] b);
    logic [7:0] d;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'h61 + 8'd10;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'h41 + 8'd10;
    end else begin
      d = b;
    end
    return d[3:0];
  endfunction

  logic [COLOR_W-1:0] color;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      color[4*k +: 4] = hex_digit(in_hex_text[8*k +: 8]);
    end
  end

  assign busy   = q_full;
  assign q_push = start && !q_full;

  always_comb begin
    q_item.cmd     = in_command;
    q_item.code    = in_code;
    q_item.color   = color;
    q_item.hdr_bad = (in_header_width  != 16'(cfg.image_width))
                  || (in_header_height != 16'(cfg.image_height))
                  || (in_header_colors != 16'(cfg.color_count))
                  || (in_header_chars  != 16'(cfg.code_chars));
  end

endmodule

### hdl/pid_queue.sv
// Two-entry request queue between front and back end.
module pid_queue
  import pid_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  valid,
  output item_t head
);

  item_t       entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_pop;

  assign full   = count_r == 2'd2;
  assign valid  = count_r != 2'd0;
  assign head   = entry_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hdl/pid_back.sv
// Back end: palette store, pixel search, address counters and results.
module pid_back
  import pid_pkg::*;
#(
  parameter int MAX_COLORS     = 256,
  parameter int MAX_CODE_CHARS = 4,
  parameter int MAX_SIDE       = 4096
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  res_strobe,
  output res_t  res
);

  localparam int AW       = $clog2(MAX_COLORS);
  localparam int LW       = AW + 1;
  localparam int NLIM     = MAX_COLORS > 511 ? 511 : MAX_COLORS;
  localparam int CNT_W    = $clog2(NLIM + 1);
  localparam int SIDE_LIM = MAX_SIDE > 8191 ? 8191 : MAX_SIDE;
  localparam int COL_W    = $clog2(SIDE_LIM);
  localparam int ROW_W    = $clog2(SIDE_LIM + 1);
  localparam int CC_LIM   = MAX_CODE_CHARS > 4 ? 4 : MAX_CODE_CHARS;
  localparam int RAM_W    = CODE_W + COLOR_W;
  localparam int PROD_W   = 2 * CFG_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  function automatic logic codes_match(input logic [CODE_W-1:0] a,
                                       input logic [CODE_W-1:0] b,
                                       input logic [2:0]        nc);
    logic eq;
    logic done;
    eq   = 1'b1;
    done = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!done && k < int'(nc)) begin
        if (a[8*k +: 8] != b[8*k +: 8]) begin
          eq   = 1'b0;
          done = 1'b1;
        end else if (a[8*k +: 8] == 8'd0) begin
          done = 1'b1;
        end
      end
    end
    return eq;
  endfunction

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    loaded_r, loaded_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [AW-1:0]       scan_slot_r, scan_slot_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic [INDEX_W-1:0]  idx_r, idx_nxt;
  logic                strobe_r, strobe_nxt;
  res_t                res_r, res_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [RAM_W-1:0]    ram_wdata;
  logic [RAM_W-1:0]    ram_q;

  logic [CNT_W-1:0]    n_use;
  logic [CFG_W-1:0]    w_use;
  logic [CFG_W-1:0]    w_lim;
  logic [CFG_W-1:0]    h_use;
  logic [2:0]          nc_use;
  logic [CFG_W:0]      col_inc;
  logic [COL_W-1:0]    col_adv;
  logic [ROW_W-1:0]    row_adv;
  logic [PROD_W-1:0]   prod;
  logic                row_live;
  logic                hit;
  logic                last;
  logic [LW-1:0]       slot_w;

  pid_ram #(.WIDTH(RAM_W), .DEPTH(MAX_COLORS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_comb begin
    n_use  = (int'(cfg.color_count) > NLIM) ? CNT_W'(NLIM) : CNT_W'(cfg.color_count);
    w_lim  = (int'(cfg.image_width) > SIDE_LIM) ? CFG_W'(SIDE_LIM) : cfg.image_width;
    w_use  = (w_lim == '0) ? CFG_W'(1) : w_lim;
    h_use  = (int'(cfg.image_height) > SIDE_LIM) ? CFG_W'(SIDE_LIM) : cfg.image_height;
    nc_use = (int'(cfg.code_chars) > CC_LIM) ? 3'(CC_LIM) : cfg.code_chars;

    row_live = CFG_W'(row_r) < h_use;
    col_inc  = (CFG_W + 1)'(col_r) + (CFG_W + 1)'(1);
    if (col_inc >= (CFG_W + 1)'(w_use)) begin
      col_adv = '0;
      row_adv = row_r + ROW_W'(1);
    end else begin
      col_adv = col_inc[COL_W-1:0];
      row_adv = row_r;
    end

    prod   = PROD_W'(row_r) * PROD_W'(w_use);
    slot_w = LW'(n_use) - LW'(loaded_r) - LW'(1);
    hit    = codes_match(code_r, ram_q[RAM_W-1 -: CODE_W], nc_use);
    last   = (LW'(scan_slot_r) + LW'(1)) == LW'(n_use);
  end

  assign ram_raddr = (state_r == S_SCAN) ? scan_slot_r + AW'(1) : '0;
  assign ram_waddr = slot_w[AW-1:0];
  assign ram_wdata = {q_item.code, q_item.color};

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    scan_slot_nxt = scan_slot_r;
    code_nxt      = code_r;
    idx_nxt       = idx_r;
    strobe_nxt    = 1'b0;
    res_nxt       = '0;
    ram_we        = 1'b0;
    q_pop         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          strobe_nxt = 1'b1;
          unique case (q_item.cmd)
            CMD_HEADER: begin
              res_nxt.status = q_item.hdr_bad ? ST_HDR_BAD : ST_OK;
              loaded_nxt     = '0;
              col_nxt        = '0;
              row_nxt        = '0;
            end
            CMD_PALETTE: begin
              if (loaded_r < n_use) begin
                ram_we     = 1'b1;
                loaded_nxt = loaded_r + CNT_W'(1);
              end
            end
            CMD_PIXEL: begin
              if (row_live) begin
                if (n_use == '0) begin
                  res_nxt.status = ST_MISS;
                  col_nxt        = col_adv;
                  row_nxt        = row_adv;
                end else begin
                  strobe_nxt    = 1'b0;
                  state_nxt     = S_SCAN;
                  scan_slot_nxt = '0;
                  code_nxt      = q_item.code;
                  idx_nxt       = INDEX_W'(prod + PROD_W'(col_r));
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          strobe_nxt          = 1'b1;
          res_nxt.pixel_valid = 1'b1;
          res_nxt.pixel_index = idx_r;
          res_nxt.pixel_value = {ram_q[COLOR_W-1:0], 8'h00};
          col_nxt             = col_adv;
          row_nxt             = row_adv;
          state_nxt           = S_IDLE;
        end else if (last) begin
          strobe_nxt     = 1'b1;
          res_nxt.status = ST_MISS;
          col_nxt        = col_adv;
          row_nxt        = row_adv;
          state_nxt      = S_IDLE;
        end else begin
          scan_slot_nxt = scan_slot_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      loaded_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_slot_r <= scan_slot_nxt;
    code_r      <= code_nxt;
    idx_r       <= idx_nxt;
    res_r       <= res_nxt;
  end

  assign res_strobe = strobe_r;
  assign res        = res_r;

endmodule

### hdl/palette_image_decoder_unit.sv
// Top level of the palette image decoder: configuration, front end, queue, back end.
//
// A request is taken when start is high and busy is low; busy rises only
// when the two-entry queue is full. Every request yields exactly one result,
// shown for one cycle with out_strobe high; the receiver cannot stall it.
// Header, palette and ignored requests are handled in the idle state of the
// back end, and their result passes through the queue and the result register.
// A pixel request searches the palette RAM one slot per cycle from slot 0,
// up to the number of colours in use, and stops at the first slot that
// matches; the single read port of the palette RAM sets this pace.
// Configuration writes take effect at once and are meant for idle periods only.
module palette_image_decoder_unit
  import pid_pkg::*;
#(
  parameter int MAX_COLORS     = 256,
  parameter int MAX_CODE_CHARS = 4,
  parameter int MAX_SIDE       = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [31:0]        in_code,
  input  logic [47:0]        in_hex_text,
  input  logic [15:0]        in_header_width,
  input  logic [15:0]        in_header_height,
  input  logic [15:0]        in_header_colors,
  input  logic [15:0]        in_header_chars,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic               out_pixel_valid,
  output logic [INDEX_W-1:0] out_pixel_index,
  output logic [VALUE_W-1:0] out_pixel_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_full;
  logic  q_push;
  item_t push_item;
  logic  q_valid;
  item_t q_head;
  logic  q_pop;
  res_t  res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_data;
        CFG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_data;
        CFG_COLOR_COUNT:  cfg_nxt.color_count  = cfg_data[8:0];
        CFG_CODE_CHARS:   cfg_nxt.code_chars   = cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= 13'd1;
      cfg_r.image_height <= 13'd1;
      cfg_r.color_count  <= 9'd1;
      cfg_r.code_chars   <= 3'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pid_front u_front (
    .start            (start),
    .q_full           (q_full),
    .cfg              (cfg_r),
    .in_command       (in_command),
    .in_code          (in_code),
    .in_hex_text      (in_hex_text),
    .in_header_width  (in_header_width),
    .in_header_height (in_header_height),
    .in_header_colors (in_header_colors),
    .in_header_chars  (in_header_chars),
    .busy             (busy),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  pid_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  pid_back #(
    .MAX_COLORS     (MAX_COLORS),
    .MAX_CODE_CHARS (MAX_CODE_CHARS),
    .MAX_SIDE       (MAX_SIDE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .res_strobe (out_strobe),
    .res        (res)
  );

  assign out_status      = res.status;
  assign out_pixel_valid = res.pixel_valid;
  assign out_pixel_index = res.pixel_index;
  assign out_pixel_value = res.pixel_value;

endmodule
